[design/csc_pkg.sv]
// ============================================================================
// csc_pkg : shared constants for the CORDIC sine/cosine core
// Decimal angle and gain constants, arctangent table and the rounding helper
// that turns a decimal constant into a fixed-point value at elaboration.
// ============================================================================
package csc_pkg;

    localparam int DEFAULT_MAX_ITERATIONS = 31;
    localparam int DEFAULT_DATA_WIDTH     = 32;
    localparam int ATAN_LEN               = 31;
    localparam int ITER_W                 = 5;
    localparam int IN_FRAC                = 28;
    localparam int OUT_FRAC               = 30;
    localparam int IO_W                   = 32;
    localparam int CFG_AW                 = 3;
    localparam int CFG_DW                 = 32;

    // register indexes (byte address = 4 * index)
    localparam int REG_ITERATION_COUNT = 0;

    localparam logic [ITER_W-1:0] ITER_COUNT_RESET = 5'd31;

    // decimal constants in units of 1e-10
    localparam longint unsigned DEC_ONE  = 64'd10000000000;
    localparam longint unsigned PI_DEC   = 64'd31415926536;
    localparam longint unsigned PI2_DEC  = 64'd15707963268;
    localparam longint unsigned PI4_DEC  = 64'd7853981634;
    localparam longint unsigned GAIN_DEC = 64'd6072529300;

    localparam longint unsigned ATAN_DEC [ATAN_LEN] = '{
        64'd7853981600, 64'd4636476100, 64'd2449786600, 64'd1243549900,
        64'd624188100,  64'd312398300,  64'd156237300,  64'd78123400,
        64'd39062300,   64'd19531200,   64'd9765600,    64'd4882800,
        64'd2441400,    64'd1220700,    64'd610350,     64'd305180,
        64'd152590,     64'd76290,      64'd38150,      64'd19070,
        64'd9540,       64'd4770,       64'd2380,       64'd1190,
        64'd600,        64'd300,        64'd150,        64'd75,
        64'd40,         64'd20,         64'd10
    };

    // Round a non-negative decimal to frac fraction bits, ties up.
    // Only used to build constants at elaboration.
    function automatic longint dec_to_fixed(input longint unsigned v, input int frac);
        longint unsigned q;
        longint unsigned r;
        q = v / DEC_ONE;
        r = v % DEC_ONE;
        for (int k = 0; k <= frac; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= DEC_ONE) begin
                r = r - DEC_ONE;
                q = q | 64'd1;
            end
        end
        return longint'((q + 64'd1) >> 1);
    endfunction

endpackage

[design/cordic_sine_cosine_core.sv]
// ============================================================================
// cordic_sine_cosine_core : pipelined CORDIC sine and cosine
// Stages in order: wrap, fold to pi/2, fold to pi/4 and load, one per
// micro-rotation (31 at the default), combine, output. Throughput: one angle
// per cycle unless the skid register is full; each micro-rotation owns one
// register stage. When the sink stalls, a one-entry skid register takes the
// result in flight and the whole pipe then holds until the sink takes it.
// Reset (synchronous, active low) empties the pipeline and sets the
// iteration count to 31.
// ============================================================================
module cordic_sine_cosine_core #(
    parameter int MAX_ITERATIONS = csc_pkg::DEFAULT_MAX_ITERATIONS,
    parameter int DATA_WIDTH     = csc_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csc_pkg::CFG_AW-1:0]     paddr,
    input  logic [csc_pkg::CFG_DW-1:0]     pwdata,
    output logic [csc_pkg::CFG_DW-1:0]     prdata,
    output logic                           pready,
    // angle stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [csc_pkg::IO_W-1:0]       s_axis_tdata,   // [31:0] angle
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [2*csc_pkg::IO_W-1:0]     m_axis_tdata    // [31:0] sine, [63:32] cosine
);

    localparam int AW       = DATA_WIDTH + 2;
    localparam int XW       = DATA_WIDTH + 1;
    localparam int QW       = XW + 16;
    localparam int ANG_FRAC = DATA_WIDTH - 4;
    localparam int XY_FRAC  = DATA_WIDTH - 2;
    localparam int NST      = MAX_ITERATIONS + 5;
    localparam int LAST     = NST - 1;
    localparam int IW       = csc_pkg::ITER_W;
    localparam int OW       = csc_pkg::IO_W;

    localparam logic signed [AW-1:0] PI_A =
        AW'(csc_pkg::dec_to_fixed(csc_pkg::PI_DEC, ANG_FRAC));
    localparam logic signed [AW-1:0] TWO_PI_A =
        AW'(2 * csc_pkg::dec_to_fixed(csc_pkg::PI_DEC, ANG_FRAC));
    localparam logic signed [AW-1:0] PI2_A =
        AW'(csc_pkg::dec_to_fixed(csc_pkg::PI2_DEC, ANG_FRAC));
    localparam logic signed [AW-1:0] PI4_A =
        AW'(csc_pkg::dec_to_fixed(csc_pkg::PI4_DEC, ANG_FRAC));
    localparam logic signed [XW-1:0] GAIN_X =
        XW'(csc_pkg::dec_to_fixed(csc_pkg::GAIN_DEC, XY_FRAC));
    localparam logic signed [QW-1:0] SAT_HI = QW'(longint'(1) << csc_pkg::OUT_FRAC);
    localparam logic signed [QW-1:0] SAT_LO = -SAT_HI;
    localparam logic [IW-1:0]        MAX_N  = IW'(MAX_ITERATIONS);

    typedef struct packed {
        logic neg;       // negate both results
        logic swp_pos;   // folded down by pi/2
        logic swp_neg;   // folded up by pi/2
    } t_flags;

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    logic [IW-1:0] r_iter;
    logic          w_cfg_wr;
    logic          w_cfg_sel;
    logic [IW-1:0] w_n;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_sel = (paddr[csc_pkg::CFG_AW-1:2] == 1'(csc_pkg::REG_ITERATION_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= csc_pkg::ITER_COUNT_RESET;
        end else if (w_cfg_wr && w_cfg_sel) begin
            r_iter <= pwdata[IW-1:0];
        end
    end

    assign prdata = w_cfg_sel ? {{(csc_pkg::CFG_DW-IW){1'b0}}, r_iter} : '0;

    // cap the rotation count at the number of stages
    assign w_n = (r_iter > MAX_N) ? MAX_N : r_iter;

    // ------------------------------------------------------------------------
    // Pipeline control: advance whenever the skid register is empty
    // ------------------------------------------------------------------------
    logic [NST-1:0]  r_vld;
    logic            r_skid_vld;
    logic [2*OW-1:0] r_skid_data;
    logic [2*OW-1:0] r_out;
    logic            w_ce;
    logic            w_in_acc;

    assign w_ce          = !r_skid_vld;
    assign w_in_acc      = s_axis_tvalid && w_ce;
    assign s_axis_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[NST-2:0], w_in_acc};
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: rescale to the internal angle format and wrap into [-pi, pi]
    // ------------------------------------------------------------------------
    logic signed [OW-1:0] w_ang_in;
    logic signed [AW-1:0] w_ang_scl;
    logic signed [AW-1:0] n_th;
    logic signed [AW-1:0] r_th;

    assign w_ang_in = $signed(s_axis_tdata);

    // widen before a left shift so no integer bits are lost
    if (ANG_FRAC >= csc_pkg::IN_FRAC) begin : g_in_up
        assign w_ang_scl = AW'(w_ang_in) <<< (ANG_FRAC - csc_pkg::IN_FRAC);
    end else begin : g_in_dn
        assign w_ang_scl = AW'(w_ang_in >>> (csc_pkg::IN_FRAC - ANG_FRAC));
    end

    always_comb begin
        if (w_ang_scl < -PI_A) begin
            n_th = w_ang_scl + TWO_PI_A;
        end else if (w_ang_scl > PI_A) begin
            n_th = w_ang_scl - TWO_PI_A;
        end else begin
            n_th = w_ang_scl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_th <= n_th;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: fold into [-pi/2, pi/2], record the sign flip
    // ------------------------------------------------------------------------
    logic signed [AW-1:0] n_h;
    logic                 n_neg;
    logic signed [AW-1:0] r_h;
    logic                 r_neg;

    always_comb begin
        n_h   = r_th;
        n_neg = 1'b0;
        if (r_th < -PI2_A) begin
            n_h   = r_th + PI_A;
            n_neg = 1'b1;
        end else if (r_th > PI2_A) begin
            n_h   = r_th - PI_A;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_h   <= n_h;
            r_neg <= n_neg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: fold into [-pi/4, pi/4], record the sine/cosine swap,
    // load the rotation start vector
    // ------------------------------------------------------------------------
    logic signed [XW-1:0] r_x [0:MAX_ITERATIONS];
    logic signed [XW-1:0] r_y [0:MAX_ITERATIONS];
    logic signed [AW-1:0] r_z [0:MAX_ITERATIONS];
    t_flags               r_f [0:MAX_ITERATIONS];
    logic signed [AW-1:0] n_z0;
    t_flags               n_f0;

    always_comb begin
        n_z0         = r_h;
        n_f0.neg     = r_neg;
        n_f0.swp_pos = 1'b0;
        n_f0.swp_neg = 1'b0;
        if (r_h < -PI4_A) begin
            n_z0         = r_h + PI2_A;
            n_f0.swp_neg = 1'b1;
        end else if (r_h > PI4_A) begin
            n_z0         = r_h - PI2_A;
            n_f0.swp_pos = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_x[0] <= GAIN_X;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_f[0] <= n_f0;
        end
    end

    // ------------------------------------------------------------------------
    // Micro-rotation stages; stages at or beyond the iteration count pass
    // the vector through. A zero residual turns negatively.
    // ------------------------------------------------------------------------
    for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_rot
        localparam logic signed [AW-1:0] ATAN_K =
            AW'(csc_pkg::dec_to_fixed(csc_pkg::ATAN_DEC[k], ANG_FRAC));
        localparam logic [IW-1:0] K_IDX = IW'(k);

        logic signed [XW-1:0] w_xs;
        logic signed [XW-1:0] w_ys;
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic signed [AW-1:0] n_z;
        logic                 w_act;
        logic                 w_pos;

        assign w_xs  = r_x[k] >>> k;
        assign w_ys  = r_y[k] >>> k;
        assign w_act = (K_IDX < w_n);
        assign w_pos = !r_z[k][AW-1] && (r_z[k] != '0);

        always_comb begin
            if (!w_act) begin
                n_x = r_x[k];
                n_y = r_y[k];
                n_z = r_z[k];
            end else if (w_pos) begin
                n_x = r_x[k] - w_ys;
                n_y = r_y[k] + w_xs;
                n_z = r_z[k] - ATAN_K;
            end else begin
                n_x = r_x[k] + w_ys;
                n_y = r_y[k] - w_xs;
                n_z = r_z[k] + ATAN_K;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_x[k+1] <= n_x;
                r_y[k+1] <= n_y;
                r_z[k+1] <= n_z;
                r_f[k+1] <= r_f[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Combine: absolute cosine magnitude, swap and sign
    // ------------------------------------------------------------------------
    logic signed [XW-1:0] w_xa;
    logic signed [XW-1:0] w_yf;
    t_flags               w_ff;
    logic signed [XW-1:0] n_sn;
    logic signed [XW-1:0] n_cs;
    logic signed [XW-1:0] r_sn;
    logic signed [XW-1:0] r_cs;

    assign w_yf = r_y[MAX_ITERATIONS];
    assign w_ff = r_f[MAX_ITERATIONS];
    assign w_xa = r_x[MAX_ITERATIONS][XW-1] ? -r_x[MAX_ITERATIONS] : r_x[MAX_ITERATIONS];

    always_comb begin
        if (w_ff.swp_pos) begin
            n_sn = w_xa;
            n_cs = -w_yf;
        end else if (w_ff.swp_neg) begin
            n_sn = -w_xa;
            n_cs = w_yf;
        end else begin
            n_sn = w_yf;
            n_cs = w_xa;
        end
        if (w_ff.neg) begin
            n_sn = -n_sn;
            n_cs = -n_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sn <= n_sn;
            r_cs <= n_cs;
        end
    end

    // ------------------------------------------------------------------------
    // Output stage: rescale to Q2.30 and clamp to plus or minus one
    // ------------------------------------------------------------------------
    logic signed [QW-1:0] w_qs;
    logic signed [QW-1:0] w_qc;
    logic signed [QW-1:0] w_cs_sat;
    logic signed [QW-1:0] w_sn_sat;

    if (XY_FRAC >= csc_pkg::OUT_FRAC) begin : g_out_dn
        assign w_qs = QW'(r_sn) >>> (XY_FRAC - csc_pkg::OUT_FRAC);
        assign w_qc = QW'(r_cs) >>> (XY_FRAC - csc_pkg::OUT_FRAC);
    end else begin : g_out_up
        assign w_qs = QW'(r_sn) <<< (csc_pkg::OUT_FRAC - XY_FRAC);
        assign w_qc = QW'(r_cs) <<< (csc_pkg::OUT_FRAC - XY_FRAC);
    end

    assign w_sn_sat = (w_qs > SAT_HI) ? SAT_HI : ((w_qs < SAT_LO) ? SAT_LO : w_qs);
    assign w_cs_sat = (w_qc > SAT_HI) ? SAT_HI : ((w_qc < SAT_LO) ? SAT_LO : w_qc);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out <= {w_cs_sat[OW-1:0], w_sn_sat[OW-1:0]};
        end
    end

    // ------------------------------------------------------------------------
    // Skid register: hold a result that was not taken while the pipe advanced
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (w_ce) begin
            r_skid_vld <= r_vld[LAST] && !m_axis_tready;
        end else if (m_axis_tready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce && r_vld[LAST] && !m_axis_tready) begin
            r_skid_data <= r_out;
        end
    end

    assign m_axis_tvalid = r_skid_vld || r_vld[LAST];
    assign m_axis_tdata  = r_skid_vld ? r_skid_data : r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // a frozen pipe keeps its occupancy
    a_hold_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(r_vld))
        else $error("pipeline valid bits moved while stalled");

    // the skid register only fills from a valid result
    a_skid_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_vld[LAST]))
        else $error("skid register filled without a valid result");

    // both results stay within plus or minus one
    a_out_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[OW-1:0]) <= $signed(SAT_HI[OW-1:0])) &&
            ($signed(m_axis_tdata[OW-1:0]) >= $signed(SAT_LO[OW-1:0])) &&
            ($signed(m_axis_tdata[2*OW-1:OW]) <= $signed(SAT_HI[OW-1:0])) &&
            ($signed(m_axis_tdata[2*OW-1:OW]) >= $signed(SAT_LO[OW-1:0])))
        else $error("result outside plus or minus one");

endmodule

[test/tb_cordic_sine_cosine_core.sv]
// ============================================================================
// tb_cordic_sine_cosine_core : self-checking bench for the CORDIC sine/cosine
// Streams angles into the core under random source gaps and sink stalls,
// predicts sine and cosine bit for bit and compares every result in order.
// The iteration count is written and read back over the APB port between
// phases, with the pipeline drained first.
// ============================================================================
module tb_cordic_sine_cosine_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITER = 31;
    localparam int LATENCY  = MAX_ITER + 5;
    localparam int ANG_FRAC = 28;
    localparam int XY_FRAC  = 30;

    localparam logic [csc_pkg::CFG_AW-1:0] ADDR_ITER  =
        csc_pkg::CFG_AW'(csc_pkg::REG_ITERATION_COUNT * 4);
    localparam logic [csc_pkg::CFG_AW-1:0] ADDR_SPARE = csc_pkg::CFG_AW'(4);

    // decimal angle constants, units of 1e-10
    localparam longint unsigned PI_DECIMAL      = 64'd31415926536;
    localparam longint unsigned HALF_PI_DECIMAL = 64'd15707963268;
    localparam longint unsigned QTR_PI_DECIMAL  = 64'd7853981634;
    localparam longint unsigned GAIN_DECIMAL    = 64'd6072529300;
    localparam longint unsigned ARCTAN_DECIMAL [MAX_ITER] = '{
        64'd7853981600, 64'd4636476100, 64'd2449786600, 64'd1243549900,
        64'd624188100,  64'd312398300,  64'd156237300,  64'd78123400,
        64'd39062300,   64'd19531200,   64'd9765600,    64'd4882800,
        64'd2441400,    64'd1220700,    64'd610350,     64'd305180,
        64'd152590,     64'd76290,      64'd38150,      64'd19070,
        64'd9540,       64'd4770,       64'd2380,       64'd1190,
        64'd600,        64'd300,        64'd150,        64'd75,
        64'd40,         64'd20,         64'd10
    };

    typedef enum logic [1:0] {FOLD_NONE, FOLD_PLUS, FOLD_MINUS} t_fold;

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] sine;
        logic [31:0] cosine;
    } t_sincos;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [csc_pkg::CFG_AW-1:0]       paddr = '0;
    logic [csc_pkg::CFG_DW-1:0]       pwdata = '0;
    logic [csc_pkg::CFG_DW-1:0]       prdata;
    logic                             pready;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [csc_pkg::IO_W-1:0]         s_axis_tdata = '0;   // [31:0] angle
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [2*csc_pkg::IO_W-1:0]       m_axis_tdata;        // [31:0] sine, [63:32] cosine

    // fixed-point constants, built at time zero
    longint pi_q, half_pi_q, qtr_pi_q, gain_q;
    longint arctan_q [MAX_ITER];

    logic [csc_pkg::ITER_W-1:0] iter_model = csc_pkg::ITER_COUNT_RESET;
    t_sincos                    pending_results[$];
    int                         errors = 0;
    bit                         calm = 1'b0;
    int                         src_window = 0;
    bit                         src_busy = 1'b0;
    int                         snk_window = 0;
    bit                         snk_busy = 1'b0;

    cordic_sine_cosine_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAIL cordic_sine_cosine_core");
        $finish;
    end

    // Round a decimal constant to frac fraction bits, ties up
    function automatic longint round_const(input longint unsigned dec, input int frac);
        logic [127:0] scaled;
        scaled = ({64'd0, dec} << (frac + 1)) / 128'd10000000000;
        return longint'((scaled + 128'd1) >> 1);
    endfunction

    task automatic build_constants();
        pi_q      = round_const(PI_DECIMAL, ANG_FRAC);
        half_pi_q = round_const(HALF_PI_DECIMAL, ANG_FRAC);
        qtr_pi_q  = round_const(QTR_PI_DECIMAL, ANG_FRAC);
        gain_q    = round_const(GAIN_DECIMAL, XY_FRAC);
        for (int i = 0; i < MAX_ITER; i++) begin
            arctan_q[i] = round_const(ARCTAN_DECIMAL[i], ANG_FRAC);
        end
    endtask

    // Saturate a Q2.30 value to plus or minus one
    function automatic logic [31:0] clamp_unit(input longint v);
        longint lim;
        lim = longint'(1) << XY_FRAC;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[31:0];
    endfunction

    // Wrap, fold, rotate and sign-correct one angle
    function automatic t_sincos predict_sincos(input logic [31:0] angle,
                                               input logic [csc_pkg::ITER_W-1:0] count);
        t_sincos r;
        longint  theta, x, y, acc, xs, ys, sn, cs;
        logic    flip;
        t_fold   fold;
        int      steps;
        theta = longint'($signed(angle));
        flip  = 1'b0;
        fold  = FOLD_NONE;

        // wrap into [-pi, pi]
        if (theta < -pi_q) theta += 2 * pi_q;
        if (theta > pi_q) theta -= 2 * pi_q;

        // fold into [-pi/2, pi/2], then [-pi/4, pi/4]
        if (theta < -half_pi_q) begin
            theta += pi_q;
            flip = 1'b1;
        end else if (theta > half_pi_q) begin
            theta -= pi_q;
            flip = 1'b1;
        end
        if (theta < -qtr_pi_q) begin
            theta += half_pi_q;
            fold = FOLD_MINUS;
        end else if (theta > qtr_pi_q) begin
            theta -= half_pi_q;
            fold = FOLD_PLUS;
        end

        steps = int'(count);
        if (steps > MAX_ITER) steps = MAX_ITER;

        // micro-rotations; a zero residual turns negative
        x   = gain_q;
        y   = 0;
        acc = 0;
        for (int i = 0; i < steps; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (theta - acc > 0) begin
                x   = x - ys;
                y   = y + xs;
                acc = acc + arctan_q[i];
            end else begin
                x   = x + ys;
                y   = y - xs;
                acc = acc - arctan_q[i];
            end
        end

        if (x < 0) x = -x;

        case (fold)
            FOLD_PLUS: begin
                sn = x;
                cs = -y;
            end
            FOLD_MINUS: begin
                sn = -x;
                cs = y;
            end
            default: begin
                sn = y;
                cs = x;
            end
        endcase
        if (flip) begin
            sn = -sn;
            cs = -cs;
        end

        r.angle  = angle;
        r.sine   = clamp_unit(sn);
        r.cosine = clamp_unit(cs);
        return r;
    endfunction

    // Random angle, weighted toward wrap, fold and zero-residual corners
    function automatic logic [31:0] pick_angle();
        logic [31:0] r;
        longint      a;
        longint      k;
        int          terms;
        bit          neg;
        r = $urandom();
        a = 0;
        case ($urandom_range(0, 9))
            4: begin
                k = longint'($urandom_range(0, 10)) - 5;
                a = k * half_pi_q + longint'($urandom_range(0, 16)) - 8;
            end
            5: begin
                a = longint'($urandom_range(0, 8191)) - 4096;
            end
            6: begin
                if ($urandom_range(0, 1) == 1) return 32'h7FFF_FFFF - 32'($urandom_range(0, 15));
                return 32'h8000_0000 + 32'($urandom_range(0, 15));
            end
            7: begin
                k = longint'($urandom_range(0, 8)) - 4;
                a = k * half_pi_q + ($urandom_range(0, 1) == 1 ? qtr_pi_q : -qtr_pi_q)
                    + longint'($urandom_range(0, 4)) - 2;
            end
            8: begin
                // alternating arctangent sums land the residual exactly on zero
                terms = $urandom_range(1, 12);
                neg   = $urandom_range(0, 1);
                for (int j = 0; j < terms; j++) begin
                    a = ((j % 2 == 0) != neg) ? a + arctan_q[j] : a - arctan_q[j];
                end
                k = longint'($urandom_range(0, 2)) - 1;
                a = a + k * half_pi_q;
            end
            default: return r;
        endcase
        return a[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] angle,
                                   input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch: %s angle=%h got=%h want=%h", what, angle, got, want);
    endtask

    // Send one angle; record its expected result on acceptance
    task automatic send_angle(input logic [31:0] angle);
        if (!calm) begin
            if (src_window == 0) begin
                src_window = $urandom_range(20, 200);
                src_busy   = ($urandom_range(0, 2) != 0);
            end
            src_window--;
            if (src_busy && $urandom_range(0, 5) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angle;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_sincos(angle, iter_model));
    endtask

    // Drop valid and hold until every expected result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic apb_write(input logic [csc_pkg::CFG_AW-1:0] addr,
                             input logic [csc_pkg::CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ITER) iter_model = data[csc_pkg::ITER_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [csc_pkg::CFG_AW-1:0] addr,
                            output logic [csc_pkg::CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_iter_readback();
        logic [csc_pkg::CFG_DW-1:0] rd;
        apb_read(ADDR_ITER, rd);
        if (rd !== csc_pkg::CFG_DW'(iter_model)) begin
            report_mismatch("iteration_count readback", '0, rd,
                            csc_pkg::CFG_DW'(iter_model));
        end
    endtask

    // Drain, write the iteration count and read it back
    task automatic configure_iterations(input logic [csc_pkg::CFG_DW-1:0] wdata);
        wait_drained();
        apb_write(ADDR_ITER, wdata);
        check_iter_readback();
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_sincos want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, m_axis_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.sine) begin
                    report_mismatch("sine", want.angle, m_axis_tdata[31:0], want.sine);
                end
                if (m_axis_tdata[63:32] !== want.cosine) begin
                    report_mismatch("cosine", want.angle, m_axis_tdata[63:32], want.cosine);
                end
            end
        end
    end

    // Sink back-pressure in random bursts, quiet stretches in between
    initial begin : sink_stall
        forever begin
            @(posedge i_clk);
            if (snk_window == 0) begin
                snk_window = $urandom_range(30, 300);
                snk_busy   = ($urandom_range(0, 2) != 0);
            end
            snk_window--;
            if (!calm && snk_busy && $urandom_range(0, 6) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_reset_value();
        check_iter_readback();
    endtask

    task automatic test_directed_angles();
        longint angles[$];
        angles = '{0, 1, -1, 64'sh7FFF_FFFF, -64'sh8000_0000,
                   pi_q, -pi_q, pi_q + 1, -pi_q - 1,
                   half_pi_q, half_pi_q + 1, -half_pi_q, -half_pi_q - 1,
                   qtr_pi_q, qtr_pi_q + 1, -qtr_pi_q, -qtr_pi_q - 1,
                   arctan_q[0], -arctan_q[0], arctan_q[0] - arctan_q[1],
                   arctan_q[0] - arctan_q[1] + arctan_q[2],
                   3 * half_pi_q, -3 * half_pi_q, 64'sh5555_5555, 64'sh2AAA_AAAA};
        foreach (angles[i]) send_angle(angles[i][31:0]);
        send_angle(32'hAAAA_AAAA);
        wait_drained();
    endtask

    task automatic test_iteration_extremes();
        logic [csc_pkg::CFG_DW-1:0] counts[$];
        counts = '{32'd0, 32'd1, 32'd2, 32'd30, 32'd31};
        foreach (counts[c]) begin
            configure_iterations(counts[c]);
            send_angle(32'd0);
            send_angle(qtr_pi_q[31:0]);
            send_angle(arctan_q[0][31:0]);
            send_angle(32'(-half_pi_q - 1));
            send_angle(32'h7FFF_FFFF);
            send_angle(32'h8000_0000);
            repeat (3) send_angle($urandom());
        end
        // a write past the register list leaves the count alone
        wait_drained();
        apb_write(ADDR_SPARE, 32'd0);
        check_iter_readback();
        repeat (4) send_angle(pick_angle());
        wait_drained();
    endtask

    task automatic test_random_angles();
        logic [csc_pkg::CFG_DW-1:0] cfg;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: cfg = 32'd31;
                1: cfg = 32'd0;
                2: cfg = 32'd1;
                default: cfg = $urandom_range(0, 31);
            endcase
            // stray upper bits are dropped by the 5-bit register
            if (ph >= 7) cfg = cfg | ($urandom() & 32'hFFFF_FFE0);
            configure_iterations(cfg);
            for (int k = 0; k < 125; k++) begin
                if (ph == 4 && k == 60) wait_drained();
                send_angle(pick_angle());
            end
        end
    endtask

    task automatic test_steady_stream();
        configure_iterations(32'd31);
        calm = 1'b1;
        repeat (60) send_angle(pick_angle());
    endtask

    // Sequence
    initial begin
        build_constants();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_value();
        test_directed_angles();
        test_iteration_extremes();
        test_random_angles();
        test_steady_stream();

        // drain, then watch for stray results
        s_axis_tvalid <= 1'b0;
        for (int k = 0; k < 20000 && pending_results.size() != 0; k++) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        while (pending_results.size() != 0) begin
            report_mismatch("missing result", pending_results[0].angle, '0,
                            pending_results[0].sine);
            void'(pending_results.pop_front());
        end

        if (errors == 0) begin
            $display("PASS cordic_sine_cosine_core");
        end else begin
            $display("FAIL cordic_sine_cosine_core");
        end
        $finish;
    end

endmodule

[filelist.f]
design/csc_pkg.sv
design/cordic_sine_cosine_core.sv
test/tb_cordic_sine_cosine_core.sv
